// ----- sv/rdce_pkg.sv -----
// Package for the run-length encoder with decimal counts.
// Holds the counter width, the job word passed from front to back, and BCD helpers.
// No dependencies.
`timescale 1ns / 1ps

package rdce_pkg;

  // Number of decimal digits in the run-length counter.
  localparam int COUNT_DIGITS = 5;
  localparam int BCD_W        = 4 * COUNT_DIGITS;
  localparam int DIG_IDX_W    = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  // Depth of the job queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef logic [BCD_W-1:0]     bcd_t;
  typedef logic [DIG_IDX_W-1:0] dig_idx_t;

  localparam bcd_t BCD_ONE = BCD_W'(1);

  // One run to be written out: its byte, its length, and the flags that go
  // on the last output word of the run.
  typedef struct packed {
    logic [7:0] sym;
    bcd_t       len;
    logic       last;
    logic       done;
  } rdce_job_t;

  // True when every digit of the counter is nine.
  function automatic logic bcd_full(input bcd_t v);
    logic r;
    r = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) begin
        r = 1'b0;
      end
    end
    return r;
  endfunction

  // Decimal increment with ripple carry over the digits.
  function automatic bcd_t bcd_inc(input bcd_t v);
    bcd_t r;
    logic carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Index of the most significant nonzero digit; zero when all are zero.
  function automatic dig_idx_t bcd_top(input bcd_t v);
    dig_idx_t r;
    r = '0;
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd0) begin
        r = DIG_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/rle_decimal_count_encoder.sv -----
// Top level of the run-length encoder with decimal counts.
// Instantiates rdce_front, rdce_fifo and rdce_back; depends on rdce_pkg.
`timescale 1ns / 1ps

// The block takes a byte stream one word at a time, with final_byte set on the
// last byte of a stream, and writes each run as its byte followed by the run
// length in ASCII decimal, most significant digit first, without leading zeros.
// Runs longer than the largest count of the decimal counter are split into
// several runs. The front end accepts one input word per cycle whenever the
// job queue has room and no second job is pending; a word that only extends
// the open run produces nothing. A final word that also closes the open run,
// because its byte differs or the counter is full, queues two jobs and holds
// off the next input word until the second job is pushed, which waits while
// the queue is full. The back end writes one output word per cycle while
// out_ready allows, so a run of length L takes 1 + (number of decimal digits
// of L) output words; for text without repeats that is two output words per
// input word, and the output channel sets the sustained rate. The four-entry
// job queue lets the front keep accepting while the back is busy or the
// output is stalled. last_of_item marks the last output word caused by one
// input word, and stream_done marks the last output word of a stream.

module rle_decimal_count_encoder
  import rdce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_item,
  output logic       stream_done
);

  // Jobs flow from the front end through the queue to the back end.
  logic      push;
  rdce_job_t push_job;
  logic      fifo_full;
  logic      pop;
  rdce_job_t pop_job;
  logic      fifo_empty;

  rdce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_job   (push_job)
  );

  rdce_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty)
  );

  rdce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .pop          (pop),
    .pop_job      (pop_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .stream_done  (stream_done)
  );

endmodule

// ----- sv/rdce_front.sv -----
// Front end of the run-length encoder: accepts input words, tracks the open run,
// and pushes one job per run to close into the job queue. Depends on rdce_pkg.
`timescale 1ns / 1ps

module rdce_front
  import rdce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  input  logic       fifo_full,
  output logic       push,
  output rdce_job_t  push_job
);

  logic [7:0] run_symbol;
  logic       run_active;
  bcd_t       run_length_bcd;

  logic       pend_valid;
  rdce_job_t  pend_job;

  logic       accept;
  logic       same;
  logic       full;
  logic       emit_old;
  bcd_t       new_len;
  rdce_job_t  old_job;
  rdce_job_t  new_job;

  assign in_ready = !pend_valid && !fifo_full;
  assign accept   = in_valid && in_ready;

  assign same     = run_active && (in_byte == run_symbol);
  assign full     = bcd_full(run_length_bcd);
  assign emit_old = run_active && (!same || full);
  assign new_len  = (same && !full) ? bcd_inc(run_length_bcd) : BCD_ONE;

  // The old run is the last job of the word only when no flush follows it.
  assign old_job = '{sym: run_symbol, len: run_length_bcd, last: !final_byte, done: 1'b0};
  assign new_job = '{sym: in_byte, len: new_len, last: 1'b1, done: 1'b1};

  always_comb begin
    if (pend_valid) begin
      push     = !fifo_full;
      push_job = pend_job;
    end else begin
      push     = accept && (emit_old || final_byte);
      push_job = emit_old ? old_job : new_job;
    end
  end

  // A final word that also closes the old run needs two jobs; the second one
  // waits here and holds off new input until it is pushed.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (!fifo_full) begin
        pend_valid <= 1'b0;
      end
    end else if (accept && final_byte && emit_old) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_byte && emit_old) begin
      pend_job <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active     <= 1'b0;
      run_symbol     <= '0;
      run_length_bcd <= '0;
    end else if (accept) begin
      if (final_byte) begin
        run_active     <= 1'b0;
        run_symbol     <= '0;
        run_length_bcd <= '0;
      end else begin
        run_active     <= 1'b1;
        run_symbol     <= in_byte;
        run_length_bcd <= new_len;
      end
    end
  end

endmodule

// ----- sv/rdce_fifo.sv -----
// Small job queue between the front and back ends of the encoder.
// Register-based, one push and one pop per cycle. Depends on rdce_pkg.
`timescale 1ns / 1ps

module rdce_fifo
  import rdce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rdce_job_t push_job,
  output logic      full,
  input  logic      pop,
  output rdce_job_t pop_job,
  output logic      empty
);

  rdce_job_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head;
  logic [FIFO_AW-1:0]   tail;
  logic [FIFO_AW:0]     count;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count != '0))
    else $error("queue count lost a push");
`endif

endmodule

// ----- sv/rdce_back.sv -----
// Back end of the encoder: pops run jobs and writes each as the run byte followed
// by its decimal length digits, through an output register. Depends on rdce_pkg.
`timescale 1ns / 1ps

module rdce_back
  import rdce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fifo_empty,
  output logic       pop,
  input  rdce_job_t  pop_job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_item,
  output logic       stream_done
);

  logic      busy;
  bcd_t      job_len;
  logic      job_last;
  logic      job_done;
  dig_idx_t  idx;

  logic       load;
  logic [3:0] digit;

  assign load  = !out_valid || out_ready;
  assign pop   = load && !busy && !fifo_empty;
  assign digit = job_len[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      if (busy) begin
        out_valid <= 1'b1;
        if (idx == '0) begin
          busy <= 1'b0;
        end
      end else begin
        out_valid <= !fifo_empty;
        busy      <= !fifo_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (busy) begin
        out_byte     <= ASCII_ZERO + {4'b0000, digit};
        last_of_item <= (idx == '0) && job_last;
        stream_done  <= (idx == '0) && job_done;
        idx          <= idx - 1'b1;
      end else if (!fifo_empty) begin
        out_byte     <= pop_job.sym;
        last_of_item <= 1'b0;
        stream_done  <= 1'b0;
        job_len      <= pop_job.len;
        job_last     <= pop_job.last;
        job_done     <= pop_job.done;
        idx          <= bcd_top(pop_job.len);
      end
    end
  end

endmodule

// ----- tb/rdce_stream_checker.sv -----
// Checker for the run-length encoder with decimal counts.
// Predicts the output words for every accepted input word and compares them in order.
// Depends on rdce_pkg for the counter size and the ASCII digit base.
`timescale 1ns / 1ps

module rdce_stream_checker
  import rdce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last_of_item,
  input  logic       stream_done,
  output int         errors,
  output int         pending
);

  // Largest count the decimal counter holds: all digits nine.
  localparam int unsigned LONGEST_RUN = 10 ** COUNT_DIGITS - 1;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       done;
  } coded_word_t;

  coded_word_t coded_words[$];
  coded_word_t item_words[0:15];
  coded_word_t oldest;
  int          item_n;

  logic [7:0]  open_sym;
  logic        open_run;
  int unsigned open_len;

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 50) begin
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    end
  endtask

  // Appends one run to the words of the current input word: the symbol, then
  // the length in decimal, most significant digit first.
  task automatic add_run(input logic [7:0] sym, input int unsigned len);
    logic [3:0]  digit[0:9];
    int unsigned rest;
    int          nd;
    item_words[item_n].code = sym;
    item_words[item_n].last = 1'b0;
    item_words[item_n].done = 1'b0;
    item_n++;
    rest     = len;
    digit[0] = 4'(rest % 10);
    rest     = rest / 10;
    nd       = 1;
    while (rest != 0) begin
      digit[nd] = 4'(rest % 10);
      rest      = rest / 10;
      nd++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      item_words[item_n].code = ASCII_ZERO + {4'd0, digit[i]};
      item_words[item_n].last = 1'b0;
      item_words[item_n].done = 1'b0;
      item_n++;
    end
  endtask

  task automatic encode_word(input logic [7:0] b, input logic fin);
    item_n = 0;
    if (!open_run) begin
      open_sym = b;
      open_len = 1;
      open_run = 1'b1;
    end else if (b == open_sym) begin
      if (open_len == LONGEST_RUN) begin
        add_run(open_sym, open_len);
        open_len = 1;
      end else begin
        open_len++;
      end
    end else begin
      add_run(open_sym, open_len);
      open_sym = b;
      open_len = 1;
    end
    if (fin) begin
      add_run(open_sym, open_len);
      open_sym = 8'h00;
      open_run = 1'b0;
      open_len = 0;
    end
    if (item_n > 0) begin
      item_words[item_n - 1].last = 1'b1;
      item_words[item_n - 1].done = fin;
    end
    for (int i = 0; i < item_n; i++) begin
      coded_words.push_back(item_words[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      open_sym = 8'h00;
      open_run = 1'b0;
      open_len = 0;
      coded_words.delete();
    end else begin
      if (in_valid && in_ready) begin
        encode_word(in_byte, final_byte);
      end
      if (out_valid && out_ready) begin
        if (coded_words.size() == 0) begin
          report("unexpected out_byte", out_byte, 0);
        end else begin
          oldest = coded_words.pop_front();
          if (out_byte !== oldest.code) begin
            report("out_byte", out_byte, oldest.code);
          end
          if (last_of_item !== oldest.last) begin
            report("last_of_item", last_of_item, oldest.last);
          end
          if (stream_done !== oldest.done) begin
            report("stream_done", stream_done, oldest.done);
          end
        end
      end
    end
    pending <= coded_words.size();
  end

endmodule

// ----- tb/tb_rle_decimal_count_encoder.sv -----
// Testbench top for the run-length encoder with decimal counts.
// Drives byte streams, throttles the output side and gives the verdict.
// Depends on rle_decimal_count_encoder and rdce_stream_checker.
`timescale 1ns / 1ps

module tb_rle_decimal_count_encoder;

  // The limit leaves ample margin for a correct run of about 460 words, even
  // with every idle burst and the long hold.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 380;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte    = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       stream_done;

  int errors;
  int pending;
  int cycle_count = 0;
  int words_sent  = 0;

  // Idling is switched on and off per stream so that some stretches run at
  // full speed; the receiver follows the same switch.
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rle_decimal_count_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .stream_done  (stream_done)
  );

  rdce_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .stream_done  (stream_done),
    .errors       (errors),
    .pending      (pending)
  );

  // Watchdog: a hung handshake or a lost output word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side. Each pass through the loop makes exactly one assignment to
  // out_ready and then waits at least one edge. A hold request from the
  // stimulus keeps ready low for a long stretch so the job queue fills and
  // the block has to drop in_ready.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one word and waits until in_ready reads high after an edge. An
  // idle burst, when one is drawn, goes before the word, so valid is only
  // lowered between words and never dropped and raised within one edge.
  task automatic send_word(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // A run of n copies of one byte; the final mark goes on its last byte when
  // asked for.
  task automatic send_run(input logic [7:0] b, input int n, input logic fin);
    for (int i = 0; i < n; i++) begin
      send_word(b, fin && (i == n - 1));
    end
  endtask

  // A well-formed stream: a few runs of random bytes, sometimes repeating the
  // previous byte so adjacent runs merge, with the final mark on the last byte.
  task automatic send_stream();
    int         nruns;
    int         len;
    int         pick;
    logic [7:0] sym;
    logic [7:0] prev;
    nruns = $urandom_range(1, 6);
    prev  = 8'($urandom_range(0, 255));
    for (int r = 0; r < nruns; r++) begin
      sym  = ($urandom_range(0, 5) == 0) ? prev : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 3);
      end else if (pick < 97) begin
        len = $urandom_range(4, 12);
      end else begin
        len = $urandom_range(95, 105);
      end
      send_run(sym, len, r == nruns - 1);
      prev = sym;
    end
  endtask

  // Noise: unrelated bytes with the final mark scattered at random and always
  // on the last one, so streams end at odd places.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      send_word(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A lone zero byte with the final mark: the reset symbol is
    // zero, yet the byte must open a new run rather than extend one.
    send_word(8'h00, 1'b1);
    // All-ones byte is data, not an end marker.
    send_run(8'hFF, 3, 1'b1);
    // A final byte that also closes a different run: two runs from one word.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    // A two-digit count, closed by the final byte of a new symbol.
    send_run(8'h7F, 10, 1'b0);
    send_word(8'h80, 1'b1);
    send_run(8'h55, 2, 1'b0);
    send_word(8'hAA, 1'b1);

    // Back-pressure: full-speed input of distinct bytes while the receiver
    // holds off, so the queue inside the block fills and in_ready drops.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_word(8'(i * 37 + 1), i == 29);
    end

    // Random part: mostly well-formed streams, some noise, idling switched
    // per stream.
    while (words_sent < RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        send_stream();
      end
    end

    // Closing part with no idling on either side: a run with a two-digit
    // count, closed by the final byte of a new symbol.
    idle_on = 1'b0;
    send_run(8'h41, 60, 1'b0);
    send_word(8'h44, 1'b1);
    in_valid <= 1'b0;

    // One edge so the checker has queued the last word's expectations, then
    // drain and give the block time to show any stray extra words.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rdce_pkg.sv
sv/rdce_front.sv
sv/rdce_fifo.sv
sv/rdce_back.sv
sv/rle_decimal_count_encoder.sv
tb/rdce_stream_checker.sv
tb/tb_rle_decimal_count_encoder.sv
